FILE: src/svs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command and status codes, and control structs for the
// vector store. Used by the controller, the datapath and the top level.
package svs_pkg;

   localparam int CMD_W       = 3;
   localparam int POS_W       = 4;
   localparam int HANDLE_IO_W = 32;
   localparam int COUNT_IO_W  = 5;
   localparam int STATUS_W    = 2;
   localparam int RD_SEL_W    = 3;

   localparam int DEF_CAPACITY     = 16;
   localparam int DEF_HANDLE_WIDTH = 32;

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

   // read address selects for the entry memory
   localparam logic [RD_SEL_W-1:0] RD_SHIFT = 3'd0;
   localparam logic [RD_SEL_W-1:0] RD_POS   = 3'd1;
   localparam logic [RD_SEL_W-1:0] RD_COUNT = 3'd2;
   localparam logic [RD_SEL_W-1:0] RD_FIRST = 3'd3;
   localparam logic [RD_SEL_W-1:0] RD_LAST  = 3'd4;

   typedef struct packed {
      logic                accept;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                cnt_clr;
      logic [STATUS_W-1:0] status;
      logic                rd_en;
      logic [RD_SEL_W-1:0] rd_sel;
      logic                wr_en;
      logic                wr_shift;
      logic                ptr_dec;
      logic                got_cap;
      logic                first_cap;
      logic                out_load;
   } svs_cmd_type;

   typedef struct packed {
      logic count_full;
      logic pos_gt_count;
      logic pos_ge_count;
      logic count_zero;
      logic ptr_at_pos;
      logic out_free;
   } svs_stat_type;

endpackage

FILE: src/svs_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the vector store: decodes each accepted word and steps the
// datapath through shift, write and readback. Depends on svs_pkg.
module svs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [svs_pkg::CMD_W-1:0]  req_command,
   output logic                       req_stall,
   input  svs_pkg::svs_stat_type      stat,
   output svs_pkg::svs_cmd_type       cmd
);
   import svs_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SHIFT_RD = 3'd1;
   localparam logic [2:0] S_SHIFT_WR = 3'd2;
   localparam logic [2:0] S_WRITE    = 3'd3;
   localparam logic [2:0] S_GOT      = 3'd4;
   localparam logic [2:0] S_FIRST    = 3'd5;
   localparam logic [2:0] S_LAST     = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic             want_got_ff, want_got_in;
   logic [CMD_W-1:0] req_command_ff, req_command_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      want_got_in = want_got_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept  = 1'b1;
               cmd.status  = ST_OK;
               want_got_in = 1'b0;
               state_in    = S_FIRST;
               unique case (req_command)
                  CMD_INSERT: begin
                     if (stat.count_full) begin
                        cmd.status = ST_FULL;
                     end else if (stat.pos_gt_count) begin
                        cmd.status = ST_BADIDX;
                     end else begin
                        cmd.cnt_inc = 1'b1;
                        state_in    = stat.pos_ge_count ? S_WRITE : S_SHIFT_RD;
                     end
                  end
                  CMD_APPEND: begin
                     if (stat.count_full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.cnt_inc = 1'b1;
                        state_in    = S_WRITE;
                     end
                  end
                  CMD_POP: begin
                     if (stat.count_zero) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.cnt_dec = 1'b1;
                        want_got_in = 1'b1;
                        state_in    = S_GOT;
                     end
                  end
                  CMD_READ: begin
                     if (stat.pos_ge_count) begin
                        cmd.status = ST_BADIDX;
                     end else begin
                        want_got_in = 1'b1;
                        state_in    = S_GOT;
                     end
                  end
                  CMD_CLEAR: begin
                     cmd.cnt_clr = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SHIFT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SHIFT;
            state_in   = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            // move one entry up, then step the pointer down toward the slot
            cmd.wr_en    = 1'b1;
            cmd.wr_shift = 1'b1;
            cmd.ptr_dec  = 1'b1;
            state_in     = stat.ptr_at_pos ? S_WRITE : S_SHIFT_RD;
         end
         S_WRITE: begin
            cmd.wr_en = 1'b1;
            state_in  = S_FIRST;
         end
         S_GOT: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = (req_command_ff == CMD_POP) ? RD_COUNT : RD_POS;
            state_in   = S_FIRST;
         end
         S_FIRST: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_FIRST;
            cmd.got_cap = want_got_ff;
            state_in    = S_LAST;
         end
         S_LAST: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_LAST;
            cmd.first_cap = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold the command of the word in flight
   assign req_command_in = cmd.accept ? req_command : req_command_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         want_got_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         want_got_ff <= want_got_in;
      end
      req_command_ff <= req_command_in;
   end

endmodule

FILE: src/svs_datapath.sv
`timescale 1ns / 1ps
// Entry memory, count, shift pointer and result register of the vector
// store. Driven by svs_ctrl through svs_cmd_type; depends on svs_pkg.
module svs_datapath #(
   parameter int CAPACITY     = svs_pkg::DEF_CAPACITY,
   parameter int HANDLE_WIDTH = svs_pkg::DEF_HANDLE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [svs_pkg::CMD_W-1:0]        req_command,
   input  logic [svs_pkg::POS_W-1:0]        req_position,
   input  logic [svs_pkg::HANDLE_IO_W-1:0]  req_handle_in,
   input  svs_pkg::svs_cmd_type             cmd,
   output svs_pkg::svs_stat_type            stat,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [svs_pkg::HANDLE_IO_W-1:0]  rsp_handle_out,
   output logic [svs_pkg::HANDLE_IO_W-1:0]  rsp_first_handle,
   output logic [svs_pkg::HANDLE_IO_W-1:0]  rsp_last_handle,
   output logic [svs_pkg::COUNT_IO_W-1:0]   rsp_entry_count,
   output logic                             rsp_is_empty,
   output logic [svs_pkg::STATUS_W-1:0]     rsp_status
);
   import svs_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [HANDLE_WIDTH-1:0] mem [CAPACITY];
   logic [HANDLE_WIDTH-1:0] rd_data_ff;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic [HANDLE_WIDTH-1:0] val_ff, val_in;
   logic [HANDLE_WIDTH-1:0] got_ff, got_in;
   logic [HANDLE_WIDTH-1:0] first_ff, first_in;
   logic [STATUS_W-1:0]     status_ff, status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_IO_W-1:0]  rsp_handle_out_ff, rsp_handle_out_in;
   logic [HANDLE_IO_W-1:0]  rsp_first_ff, rsp_first_in;
   logic [HANDLE_IO_W-1:0]  rsp_last_ff, rsp_last_in;
   logic [COUNT_IO_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   logic [CMP_W-1:0]        pos_cmp, cnt_cmp;
   logic [IDX_W-1:0]        rd_addr, wr_addr;
   logic [HANDLE_WIDTH-1:0] wr_data;

   assign pos_cmp = CMP_W'(req_position);
   assign cnt_cmp = CMP_W'(count_ff);

   assign stat.count_full   = (count_ff == CNT_W'(CAPACITY));
   assign stat.pos_gt_count = (pos_cmp > cnt_cmp);
   assign stat.pos_ge_count = (pos_cmp >= cnt_cmp);
   assign stat.count_zero   = (count_ff == '0);
   assign stat.ptr_at_pos   = ((ptr_ff - 1'b1) == pos_ff);
   assign stat.out_free     = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_SHIFT: rd_addr = ptr_ff - 1'b1;
         RD_POS:   rd_addr = pos_ff;
         RD_COUNT: rd_addr = IDX_W'(count_ff);
         RD_FIRST: rd_addr = '0;
         RD_LAST:  rd_addr = IDX_W'(count_ff - 1'b1);
         default:  rd_addr = '0;
      endcase
   end

   assign wr_addr = cmd.wr_shift ? ptr_ff : pos_ff;
   assign wr_data = cmd.wr_shift ? rd_data_ff : val_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      got_in    = got_ff;
      first_in  = first_ff;
      status_in = status_ff;
      if (cmd.accept) begin
         ptr_in    = IDX_W'(count_ff);
         // append writes at the tail
         pos_in    = (req_command == CMD_APPEND) ? IDX_W'(count_ff) : IDX_W'(req_position);
         val_in    = HANDLE_WIDTH'(req_handle_in);
         got_in    = '0;
         status_in = cmd.status;
         priority if (cmd.cnt_clr) begin
            count_in = '0;
         end else if (cmd.cnt_inc) begin
            count_in = count_ff + 1'b1;
         end else if (cmd.cnt_dec) begin
            count_in = count_ff - 1'b1;
         end else begin
            count_in = count_ff;
         end
      end
      if (cmd.ptr_dec) begin
         ptr_in = ptr_ff - 1'b1;
      end
      if (cmd.got_cap) begin
         got_in = rd_data_ff;
      end
      if (cmd.first_cap) begin
         first_in = rd_data_ff;
      end
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_handle_out_in = rsp_handle_out_ff;
      rsp_first_in      = rsp_first_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_empty_in      = rsp_empty_ff;
      rsp_status_in     = rsp_status_ff;
      if (cmd.out_load) begin
         rsp_valid_in      = 1'b1;
         rsp_handle_out_in = HANDLE_IO_W'(got_ff);
         rsp_first_in      = stat.count_zero ? '0 : HANDLE_IO_W'(first_ff);
         rsp_last_in       = stat.count_zero ? '0 : HANDLE_IO_W'(rd_data_ff);
         rsp_count_in      = COUNT_IO_W'(count_ff);
         rsp_empty_in      = stat.count_zero;
         rsp_status_in     = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff            <= ptr_in;
      pos_ff            <= pos_in;
      val_ff            <= val_in;
      got_ff            <= got_in;
      first_ff          <= first_in;
      status_ff         <= status_in;
      rsp_handle_out_ff <= rsp_handle_out_in;
      rsp_first_ff      <= rsp_first_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_empty_ff      <= rsp_empty_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_handle_out   = rsp_handle_out_ff;
   assign rsp_first_handle = rsp_first_ff;
   assign rsp_last_handle  = rsp_last_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && (cmd.status != ST_OK)) |=> (count_ff == $past(count_ff)))
      else $error("refused word changed the count");

   a_empty_clears_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> ((rsp_first_ff == '0) && (rsp_last_ff == '0)))
      else $error("empty result carries end entries");

   a_fail_no_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_handle_out_ff == '0))
      else $error("failed word returned a handle");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.ptr_dec |-> (ptr_ff > pos_ff))
      else $error("shift pointer passed the insert slot");
`endif

endmodule

FILE: src/shift_insert_vector_store.sv
`timescale 1ns / 1ps
// Ordered store of CAPACITY handles with insert-shift, append, pop, read, clear.
// One word at a time; the entry memory has one read and one write port.
// Each word ends with reads of the first and last entries; before them append does a write,
// pop and read read the taken entry, insert at p shifts entries p..count-1 up, then writes.
// Next word taken the cycle after the result loads, while that result waits in the output.
// Synchronous reset empties the store; entry contents are not cleared.
module shift_insert_vector_store #(
   parameter int CAPACITY     = svs_pkg::DEF_CAPACITY,
   parameter int HANDLE_WIDTH = svs_pkg::DEF_HANDLE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [svs_pkg::CMD_W-1:0]        req_command,
   input  logic [svs_pkg::POS_W-1:0]        req_position,
   input  logic [svs_pkg::HANDLE_IO_W-1:0]  req_handle_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [svs_pkg::HANDLE_IO_W-1:0]  rsp_handle_out,
   output logic [svs_pkg::HANDLE_IO_W-1:0]  rsp_first_handle,
   output logic [svs_pkg::HANDLE_IO_W-1:0]  rsp_last_handle,
   output logic [svs_pkg::COUNT_IO_W-1:0]   rsp_entry_count,
   output logic                             rsp_is_empty,
   output logic [svs_pkg::STATUS_W-1:0]     rsp_status
);
   import svs_pkg::*;

   svs_cmd_type  cmd;
   svs_stat_type stat;

   svs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   svs_datapath #(
      .CAPACITY     (CAPACITY),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_position     (req_position),
      .req_handle_in    (req_handle_in),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_handle_out   (rsp_handle_out),
      .rsp_first_handle (rsp_first_handle),
      .rsp_last_handle  (rsp_last_handle),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_status       (rsp_status)
   );

endmodule

FILE: tb/shift_insert_vector_store_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for shift_insert_vector_store: directed table, then bursty random words,
// each compared with its row's answer or a behavioral mirror. Depends on svs_pkg and the RTL.
module shift_insert_vector_store_tb;
   import svs_pkg::*;

   localparam int CAPACITY    = DEF_CAPACITY;
   localparam int RAND_WORDS  = 1700;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 60;
   localparam int MAX_PRINTS  = 100;

   // command codes with no operation behind them
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [HANDLE_IO_W-1:0] handle_out;
      logic [HANDLE_IO_W-1:0] first_handle;
      logic [HANDLE_IO_W-1:0] last_handle;
      logic [COUNT_IO_W-1:0]  entry_count;
      logic                   is_empty;
      logic [STATUS_W-1:0]    status;
   } svs_rsp_type;

   typedef struct {
      logic [CMD_W-1:0]       command;
      logic [POS_W-1:0]       position;
      logic [HANDLE_IO_W-1:0] handle;
      bit                     typed;
      svs_rsp_type            want;
   } plan_row_type;

   localparam svs_rsp_type NO_RSP = '0;

   logic                   clock;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_stall;
   logic [CMD_W-1:0]       req_command   = '0;
   logic [POS_W-1:0]       req_position  = '0;
   logic [HANDLE_IO_W-1:0] req_handle_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall     = 1'b0;
   logic [HANDLE_IO_W-1:0] rsp_handle_out;
   logic [HANDLE_IO_W-1:0] rsp_first_handle;
   logic [HANDLE_IO_W-1:0] rsp_last_handle;
   logic [COUNT_IO_W-1:0]  rsp_entry_count;
   logic                   rsp_is_empty;
   logic [STATUS_W-1:0]    rsp_status;

   // mirror of the store contents
   logic [HANDLE_IO_W-1:0] mirror_entries [CAPACITY];
   int                     mirror_count = 0;

   svs_rsp_type  pending_rsp [$];
   plan_row_type plan [$];
   int           mismatches  = 0;
   int           rsp_seen    = 0;
   int           cycle_count = 0;
   int           hold_asks   = 0;
   int           holds_done  = 0;

   shift_insert_vector_store dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_position     (req_position),
      .req_handle_in    (req_handle_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_handle_out   (rsp_handle_out),
      .rsp_first_handle (rsp_first_handle),
      .rsp_last_handle  (rsp_last_handle),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending", cycle_count,
                  pending_rsp.size());
         $display("shift_insert_vector_store verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [HANDLE_IO_W-1:0] got,
                                  input logic [HANDLE_IO_W-1:0] want);
      // print the first hundred, count all
      if (mismatches < MAX_PRINTS)
         $display("MISMATCH rsp word %0d %s: got %h want %h", rsp_seen, what, got, want);
      mismatches++;
   endtask

   task automatic predict_store_result(input logic [CMD_W-1:0] cmd,
                                       input logic [POS_W-1:0] pos,
                                       input logic [HANDLE_IO_W-1:0] val,
                                       output svs_rsp_type r);
      logic [HANDLE_IO_W-1:0] got;
      logic [STATUS_W-1:0]    st;
      got = '0;
      st  = ST_OK;
      case (cmd)
         CMD_INSERT: begin
            if (mirror_count >= CAPACITY) begin
               st = ST_FULL;
            end else if (int'(pos) > mirror_count) begin
               st = ST_BADIDX;
            end else begin
               for (int i = mirror_count; i > int'(pos); i--)
                  mirror_entries[i] = mirror_entries[i-1];
               mirror_entries[pos] = val;
               mirror_count++;
            end
         end
         CMD_APPEND: begin
            if (mirror_count >= CAPACITY) begin
               st = ST_FULL;
            end else begin
               mirror_entries[mirror_count] = val;
               mirror_count++;
            end
         end
         CMD_POP: begin
            if (mirror_count == 0) begin
               st = ST_EMPTY;
            end else begin
               mirror_count--;
               got = mirror_entries[mirror_count];
            end
         end
         CMD_READ: begin
            if (int'(pos) >= mirror_count) st = ST_BADIDX;
            else got = mirror_entries[pos];
         end
         CMD_CLEAR: mirror_count = 0;
         default: ;
      endcase
      r.handle_out   = got;
      r.first_handle = (mirror_count != 0) ? mirror_entries[0] : '0;
      r.last_handle  = (mirror_count != 0) ? mirror_entries[mirror_count-1] : '0;
      r.entry_count  = COUNT_IO_W'(mirror_count);
      r.is_empty     = (mirror_count == 0);
      r.status       = st;
   endtask

   task automatic issue_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [HANDLE_IO_W-1:0] val, input bit typed,
                             input svs_rsp_type typed_rsp);
      svs_rsp_type predicted;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_position  <= pos;
      req_handle_in <= val;
      do @(posedge clock); while (req_stall);
      // the mirror always advances, even where the row carries its own answer
      predict_store_result(cmd, pos, val, predicted);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic idle_cycle();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain_pending(input int max_cycles);
      int guard;
      guard = 0;
      while (pending_rsp.size() != 0 && guard < max_cycles) begin
         @(posedge clock);
         guard++;
      end
   endtask

   function automatic svs_rsp_type mk_rsp(input logic [HANDLE_IO_W-1:0] h_out,
                                          input logic [HANDLE_IO_W-1:0] first,
                                          input logic [HANDLE_IO_W-1:0] last,
                                          input int cnt, input logic empty,
                                          input logic [STATUS_W-1:0] st);
      svs_rsp_type r;
      r.handle_out   = h_out;
      r.first_handle = first;
      r.last_handle  = last;
      r.entry_count  = COUNT_IO_W'(cnt);
      r.is_empty     = empty;
      r.status       = st;
      return r;
   endfunction

   function automatic plan_row_type mk_row(input logic [CMD_W-1:0] cmd,
                                           input logic [POS_W-1:0] pos,
                                           input logic [HANDLE_IO_W-1:0] val,
                                           input bit typed, input svs_rsp_type want);
      plan_row_type p;
      p.command  = cmd;
      p.position = pos;
      p.handle   = val;
      p.typed    = typed;
      p.want     = want;
      return p;
   endfunction

   // response side: stall on shifting patterns, long hold-off on request
   initial begin
      int seg_left  = 0;
      int mode      = 0;
      int hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_asks != holds_done) begin
            holds_done = hold_asks;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(16, 120);
               mode     = $urandom_range(0, 3);
            end
            seg_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      svs_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("word with nothing pending", rsp_handle_out, '0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_handle_out !== want.handle_out)
               report_mismatch("handle_out", rsp_handle_out, want.handle_out);
            if (rsp_first_handle !== want.first_handle)
               report_mismatch("first_handle", rsp_first_handle, want.first_handle);
            if (rsp_last_handle !== want.last_handle)
               report_mismatch("last_handle", rsp_last_handle, want.last_handle);
            if (rsp_entry_count !== want.entry_count)
               report_mismatch("entry_count", HANDLE_IO_W'(rsp_entry_count),
                               HANDLE_IO_W'(want.entry_count));
            if (rsp_is_empty !== want.is_empty)
               report_mismatch("is_empty", HANDLE_IO_W'(rsp_is_empty),
                               HANDLE_IO_W'(want.is_empty));
            if (rsp_status !== want.status)
               report_mismatch("status", HANDLE_IO_W'(rsp_status), HANDLE_IO_W'(want.status));
         end
         rsp_seen++;
      end
   end

   initial begin
      int                     r;
      int                     mode;
      int                     mode_left;
      int                     burst_left;
      int                     ins_w;
      int                     app_w;
      int                     pop_w;
      int                     read_w;
      logic [CMD_W-1:0]       cmd;
      logic [POS_W-1:0]       pos;
      logic [HANDLE_IO_W-1:0] val;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty-store errors, extremes, shifts, fill to capacity, refusals
      plan.push_back(mk_row(CMD_POP, 4'd0, '0, 1, mk_rsp('0, '0, '0, 0, 1'b1, ST_EMPTY)));
      plan.push_back(mk_row(CMD_READ, 4'd0, '0, 1, mk_rsp('0, '0, '0, 0, 1'b1, ST_BADIDX)));
      plan.push_back(mk_row(CMD_INSERT, 4'd1, 32'h1234_5678, 1,
                            mk_rsp('0, '0, '0, 0, 1'b1, ST_BADIDX)));
      plan.push_back(mk_row(CMD_UNUSED_HI, 4'd15, 32'hFFFF_FFFF, 1,
                            mk_rsp('0, '0, '0, 0, 1'b1, ST_OK)));
      plan.push_back(mk_row(CMD_INSERT, 4'd0, 32'hFFFF_FFFF, 1,
                            mk_rsp('0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, ST_OK)));
      plan.push_back(mk_row(CMD_APPEND, 4'd0, 32'h0000_0000, 1,
                            mk_rsp('0, 32'hFFFF_FFFF, '0, 2, 1'b0, ST_OK)));
      plan.push_back(mk_row(CMD_INSERT, 4'd1, 32'hA5A5_A5A5, 0, NO_RSP));
      plan.push_back(mk_row(CMD_INSERT, 4'd0, 32'h5A5A_5A5A, 0, NO_RSP));
      plan.push_back(mk_row(CMD_READ, 4'd2, '0, 0, NO_RSP));
      // insert at the count acts as an append
      plan.push_back(mk_row(CMD_INSERT, 4'd4, 32'hC3C3_3C3C, 0, NO_RSP));
      for (int k = 0; k < 11; k++)
         plan.push_back(mk_row(CMD_APPEND, 4'(k), 32'h8000_0000 >> k, 0, NO_RSP));
      plan.push_back(mk_row(CMD_INSERT, 4'd15, 32'hDEAD_BEEF, 0, NO_RSP));
      plan.push_back(mk_row(CMD_APPEND, 4'd15, 32'hDEAD_BEEF, 0, NO_RSP));
      plan.push_back(mk_row(CMD_READ, 4'd15, '0, 0, NO_RSP));
      plan.push_back(mk_row(CMD_POP, 4'd0, '0, 0, NO_RSP));
      plan.push_back(mk_row(CMD_CLEAR, 4'd0, '0, 1, mk_rsp('0, '0, '0, 0, 1'b1, ST_OK)));

      foreach (plan[i]) begin
         issue_word(plan[i].command, plan[i].position, plan[i].handle, plan[i].typed,
                    plan[i].want);
         if ($urandom_range(0, 2) == 0) idle_cycle();
      end

      mode       = 0;
      mode_left  = 0;
      burst_left = 0;
      for (int n = 0; n < RAND_WORDS; n++) begin
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(24, 72);
         end
         mode_left--;
         case (mode)
            0:       begin ins_w = 35; app_w = 25; pop_w = 10; end
            1:       begin ins_w = 10; app_w = 8;  pop_w = 45; end
            default: begin ins_w = 25; app_w = 15; pop_w = 25; end
         endcase
         read_w = 85 - ins_w - app_w - pop_w;

         val = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : $urandom;
         pos = 4'($urandom_range(0, 15));
         r   = $urandom_range(0, 99);
         if (r < ins_w) begin
            cmd = CMD_INSERT;
            if (mirror_count < CAPACITY) pos = 4'($urandom_range(0, mirror_count));
         end else if (r < ins_w + app_w) begin
            cmd = CMD_APPEND;
         end else if (r < ins_w + app_w + pop_w) begin
            cmd = CMD_POP;
         end else if (r < 85) begin
            cmd = CMD_READ;
            if (mirror_count > 0) pos = 4'($urandom_range(0, mirror_count - 1));
         end else if (r < 95) begin
            // unconstrained index, often out of range
            cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_READ;
         end else if (r < 97) begin
            cmd = CMD_CLEAR;
         end else begin
            cmd = CMD_UNUSED_LO + CMD_W'($urandom_range(0, CMD_UNUSED_HI - CMD_UNUSED_LO));
         end

         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 10)) idle_cycle();
         end
         burst_left--;
         issue_word(cmd, pos, val, 0, NO_RSP);

         // hold the response side off while words keep coming
         if (n == 600 || n == 1350) hold_asks++;
         if (n == 300 || n == 1000) begin
            idle_cycle();
            drain_pending(CYCLE_LIMIT);
         end
      end

      idle_cycle();
      drain_pending(20_000);
      repeat (SETTLE) @(posedge clock);
      if (pending_rsp.size() != 0)
         report_mismatch("words never returned", pending_rsp.size(), '0);

      if (mismatches == 0) begin
         $display("shift_insert_vector_store verification clean");
      end else begin
         $display("shift_insert_vector_store verification failed");
      end
      $finish;
   end

endmodule
